>>> sv/plqa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package plqa_pkg;

  localparam int CNT_W   = 16;
  localparam int PCT_W   = 7;
  localparam int ID_W    = 8;
  localparam int GAP_W   = 7;
  localparam int LEVEL_W = 3;
  localparam int STAT_W  = 2;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 16;
  localparam int PROD_W  = CNT_W + PCT_W;

  localparam logic [CNT_W-1:0]   CNT_MAX    = '1;
  localparam logic [PCT_W-1:0]   PCT_SCALE  = 7'd100;
  localparam logic [GAP_W-1:0]   ID_LOW_MAX = 7'd127;
  localparam logic [LEVEL_W-1:0] LEVEL_MIN  = 3'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 3'd5;

  localparam logic [STAT_W-1:0] STATUS_ACCEPTED = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_REJECTED = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_CORRUPT  = 2'd2;

  localparam logic [CIDX_W-1:0] REG_WINDOW   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_INC_PCT  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_DEC_PCT  = 2'd2;

  localparam logic [CNT_W-1:0] WINDOW_RESET  = 16'd100;
  localparam logic [PCT_W-1:0] INC_PCT_RESET = 7'd5;
  localparam logic [PCT_W-1:0] DEC_PCT_RESET = 7'd10;

  typedef struct packed {
    logic             accept;
    logic [GAP_W-1:0] gap;
  } id_res_t;

  typedef struct packed {
    logic               clear;
    logic [LEVEL_W-1:0] level;
  } recon_t;

endpackage

`default_nettype wire

>>> sv/plqa_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface plqa_in_if;
  import plqa_pkg::*;
  logic            valid;
  logic            ready;
  logic            cmd;
  logic [ID_W-1:0] packet_id;
  modport source (output valid, cmd, packet_id, input ready);
  modport sink   (input valid, cmd, packet_id, output ready);
endinterface

interface plqa_out_if;
  import plqa_pkg::*;
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [GAP_W-1:0]   gap;
  logic [LEVEL_W-1:0] quality_level;
  modport source (output valid, status, gap, quality_level, input ready);
  modport sink   (input valid, status, gap, quality_level, output ready);
endinterface

interface plqa_cfg_if;
  import plqa_pkg::*;
  logic               valid;
  logic               ready;
  logic [CIDX_W-1:0]  index;
  logic [CDATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/plqa_id_check.sv
`timescale 1ns / 1ps
`default_nettype none

module plqa_id_check
  import plqa_pkg::*;
(
  input  wire logic [ID_W-1:0] id,
  input  wire logic [ID_W-1:0] prev,
  output id_res_t              res
);

  logic             wrap;
  logic [GAP_W-1:0] n;
  logic [GAP_W-1:0] p;
  logic [GAP_W:0]   wrap_gap;

  assign wrap     = id[ID_W-1] ^ prev[ID_W-1];
  assign n        = id[GAP_W-1:0];
  assign p        = prev[GAP_W-1:0];
  // Across the top-bit boundary the distance runs through the low-half wrap.
  assign wrap_gap = ({1'b0, ID_LOW_MAX} - {1'b0, p}) + {1'b0, n};

  always_comb begin
    if (wrap) begin
      res.accept = p > n;
      res.gap    = wrap_gap[GAP_W-1:0];
    end else begin
      res.accept = n > p;
      res.gap    = n - p - GAP_W'(1);
    end
    if (!res.accept) begin
      res.gap = '0;
    end
  end

endmodule

`default_nettype wire

>>> sv/plqa_level_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module plqa_level_ctrl
  import plqa_pkg::*;
(
  input  wire logic [CNT_W-1:0]   received,
  input  wire logic [CNT_W-1:0]   missing,
  input  wire logic [LEVEL_W-1:0] level,
  input  wire logic [CNT_W-1:0]   window,
  input  wire logic [PCT_W-1:0]   inc_pct,
  input  wire logic [PCT_W-1:0]   dec_pct,
  output recon_t                  res
);

  logic [PROD_W-1:0]  loss;
  logic [PROD_W-1:0]  down;
  logic [PROD_W-1:0]  up;
  logic [LEVEL_W-1:0] level_up;
  logic [LEVEL_W-1:0] level_dn;

  // Exact ratio compare: missing/received against pct/100 by cross products.
  assign loss = PROD_W'(missing) * PROD_W'(PCT_SCALE);
  assign down = PROD_W'(dec_pct) * PROD_W'(received);
  assign up   = PROD_W'(inc_pct) * PROD_W'(received);

  assign level_up = (level < LEVEL_MAX) ? level + LEVEL_W'(1) : level;
  assign level_dn = (level > LEVEL_MIN) ? level - LEVEL_W'(1) : level;

  always_comb begin
    res.clear = 1'b0;
    res.level = level;
    if (received >= window) begin
      if (missing == '0) begin
        res.level = level_up;
      end else begin
        res.clear = 1'b1;
        priority if (loss > down) begin
          res.level = level_dn;
        end else if (loss < up) begin
          res.level = level_up;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/packet_loss_quality_adapter_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Packet loss quality adapter. Each input item is one packet event (good packet
// with an 8-bit sequence id, or a corrupted packet) and yields one result item
// with the event status, the id gap and the requested quality level 1..5.
// Items flow at one per clock while the result side is not stalled: an item is
// held in the input register and its result is loaded into the output register
// once that register is free or being read; the window check, the two threshold
// products and the counter updates are all combinational logic between these
// two registers. Configuration writes are always taken (cfg ready is held high)
// and should be issued only while no items are in flight.

module packet_loss_quality_adapter_top
  import plqa_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  plqa_in_if.sink    in_ch,
  plqa_out_if.source out_ch,
  plqa_cfg_if.sink   cfg_ch
);

  logic               in_valid_r;
  logic               in_cmd_r;
  logic [ID_W-1:0]    in_id_r;
  logic               out_valid_r;
  logic [STAT_W-1:0]  out_status_r;
  logic [GAP_W-1:0]   out_gap_r;
  logic [LEVEL_W-1:0] out_level_r;

  logic [CNT_W-1:0]   window_r;
  logic [PCT_W-1:0]   inc_pct_r;
  logic [PCT_W-1:0]   dec_pct_r;

  logic [ID_W-1:0]    last_id_r;
  logic [CNT_W-1:0]   received_r;
  logic [CNT_W-1:0]   missing_r;
  logic [LEVEL_W-1:0] level_r;

  logic [ID_W-1:0]    last_id_nxt;
  logic [CNT_W-1:0]   received_nxt;
  logic [CNT_W-1:0]   missing_nxt;
  logic [STAT_W-1:0]  status_nxt;
  logic [GAP_W-1:0]   gap_nxt;

  logic               advance;
  logic               in_take;
  logic [CNT_W-1:0]   rc_base;
  logic [CNT_W-1:0]   mc_base;
  logic [CNT_W:0]     rc_sum;
  logic [CNT_W:0]     mc_sum;
  id_res_t            id_res;
  recon_t             recon;

  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.gap           = out_gap_r;
  assign out_ch.quality_level = out_level_r;

  plqa_level_ctrl u_level_ctrl (
    .received (received_r),
    .missing  (missing_r),
    .level    (level_r),
    .window   (window_r),
    .inc_pct  (inc_pct_r),
    .dec_pct  (dec_pct_r),
    .res      (recon)
  );

  plqa_id_check u_id_check (
    .id   (in_id_r),
    .prev (last_id_r),
    .res  (id_res)
  );

  // The window check runs first; the event then updates the cleared or kept counters.
  assign rc_base = recon.clear ? '0 : received_r;
  assign mc_base = recon.clear ? '0 : missing_r;
  assign rc_sum  = {1'b0, rc_base} + (CNT_W+1)'(1);
  assign mc_sum  = {1'b0, mc_base} +
                   (in_cmd_r ? (CNT_W+1)'(1) : (CNT_W+1)'(id_res.gap));

  always_comb begin
    last_id_nxt  = last_id_r;
    received_nxt = rc_base;
    missing_nxt  = mc_base;
    gap_nxt      = '0;
    if (in_cmd_r) begin
      status_nxt  = STATUS_CORRUPT;
      missing_nxt = mc_sum[CNT_W] ? CNT_MAX : mc_sum[CNT_W-1:0];
    end else if (id_res.accept) begin
      status_nxt   = STATUS_ACCEPTED;
      gap_nxt      = id_res.gap;
      last_id_nxt  = in_id_r;
      received_nxt = rc_sum[CNT_W] ? CNT_MAX : rc_sum[CNT_W-1:0];
      missing_nxt  = mc_sum[CNT_W] ? CNT_MAX : mc_sum[CNT_W-1:0];
    end else begin
      status_nxt = STATUS_REJECTED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      window_r    <= WINDOW_RESET;
      inc_pct_r   <= INC_PCT_RESET;
      dec_pct_r   <= DEC_PCT_RESET;
      last_id_r   <= '0;
      received_r  <= '0;
      missing_r   <= '0;
      level_r     <= LEVEL_MAX;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        last_id_r   <= last_id_nxt;
        received_r  <= received_nxt;
        missing_r   <= missing_nxt;
        level_r     <= recon.level;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_WINDOW:  window_r  <= cfg_ch.data[CNT_W-1:0];
          REG_INC_PCT: inc_pct_r <= cfg_ch.data[PCT_W-1:0];
          REG_DEC_PCT: dec_pct_r <= cfg_ch.data[PCT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_cmd_r <= in_ch.cmd;
      in_id_r  <= in_ch.packet_id;
    end
    if (advance) begin
      out_status_r <= status_nxt;
      out_gap_r    <= gap_nxt;
      out_level_r  <= recon.level;
    end
  end

endmodule

`default_nettype wire

>>> sim/tb_packet_loss_quality_adapter_top.sv
`timescale 1ns / 1ps

module tb_packet_loss_quality_adapter_top;
  import plqa_pkg::*;

  localparam logic [CIDX_W-1:0] REG_UNUSED  = 2'd3;
  localparam int                STALL_LIMIT = 5000;
  localparam int                HOLD_CYCLES = 300;
  localparam int                PHASE_ITEMS = 80;
  localparam int                DRAIN_WAIT  = 4;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [GAP_W-1:0]   gap;
    logic [LEVEL_W-1:0] level;
  } plqa_result_t;

  typedef struct {
    logic               cmd;
    logic [ID_W-1:0]    id;
    logic               typed;
    plqa_result_t       want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  plqa_in_if  in_if();
  plqa_out_if out_if();
  plqa_cfg_if cfg_if();

  packet_loss_quality_adapter_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Model of the adapter: configuration and event state.
  logic [CNT_W-1:0]   win_cfg   = WINDOW_RESET;
  logic [PCT_W-1:0]   inc_cfg   = INC_PCT_RESET;
  logic [PCT_W-1:0]   dec_cfg   = DEC_PCT_RESET;
  logic [ID_W-1:0]    last_id_q = '0;
  logic [CNT_W-1:0]   rcv_cnt   = '0;
  logic [CNT_W-1:0]   miss_cnt  = '0;
  logic [LEVEL_W-1:0] level_q   = LEVEL_MAX;

  plqa_result_t expected_q[$];
  dir_row_t     dir_table[$];
  plqa_result_t want_r;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_token     = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int idle_cycles    = 0;
  int mismatches     = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int phases         = 0;
  int n_accepted     = 0;
  int n_rejected     = 0;
  int n_corrupt      = 0;
  logic [7:0] levels_seen = '0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
  endfunction

  // Updates the model state for one packet event and returns its result.
  function automatic plqa_result_t predict_event(logic c, logic [ID_W-1:0] id);
    plqa_result_t r;
    logic [31:0]  loss;
    logic [31:0]  down;
    logic [31:0]  up;
    logic         wrap;
    logic [6:0]   n;
    logic [6:0]   p;
    r.status = STATUS_REJECTED;
    r.gap    = '0;
    if (rcv_cnt >= win_cfg) begin
      if (miss_cnt == '0) begin
        if (level_q < LEVEL_MAX) level_q = level_q + 1'b1;
      end else begin
        loss     = 32'(miss_cnt) * 32'(PCT_SCALE);
        down     = 32'(dec_cfg) * 32'(rcv_cnt);
        up       = 32'(inc_cfg) * 32'(rcv_cnt);
        rcv_cnt  = '0;
        miss_cnt = '0;
        if (loss > down) begin
          if (level_q > LEVEL_MIN) level_q = level_q - 1'b1;
        end else if (loss < up) begin
          if (level_q < LEVEL_MAX) level_q = level_q + 1'b1;
        end
      end
    end
    wrap = id[ID_W-1] ^ last_id_q[ID_W-1];
    n    = id[6:0];
    p    = last_id_q[6:0];
    if (c) begin
      miss_cnt = sat_add(miss_cnt, 16'd1);
      r.status = STATUS_CORRUPT;
    end else if (wrap ? (p > n) : (n > p)) begin
      r.gap     = wrap ? (ID_LOW_MAX - p) + n : n - p - 7'd1;
      rcv_cnt   = sat_add(rcv_cnt, 16'd1);
      miss_cnt  = sat_add(miss_cnt, CNT_W'(r.gap));
      last_id_q = id;
      r.status  = STATUS_ACCEPTED;
    end
    r.level = level_q;
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch at result %0d: %s = %0d, expected %0d", results_seen, field, got, want);
    mismatches++;
  endtask

  task automatic add_row(logic c, logic [ID_W-1:0] id, logic typed,
                         logic [STAT_W-1:0] st, logic [GAP_W-1:0] g, logic [LEVEL_W-1:0] lv);
    dir_row_t row;
    row.cmd         = c;
    row.id          = id;
    row.typed       = typed;
    row.want.status = st;
    row.want.gap    = g;
    row.want.level  = lv;
    dir_table.push_back(row);
  endtask

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(logic c, logic [ID_W-1:0] id, logic typed, plqa_result_t want);
    plqa_result_t pred;
    if (send_idle_pct != 0) begin
      in_if.valid = 1'b0;
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_if.valid     = 1'b1;
    in_if.cmd       = c;
    in_if.packet_id = id;
    do @(posedge clk); while (!in_if.ready);
    pred = predict_event(c, id);
    expected_q.push_back(typed ? want : pred);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_good(logic [ID_W-1:0] id);
    send_item(1'b0, id, 1'b0, '0);
  endtask

  // Mostly in-order ids with small gaps, plus large gaps, corrupt packets,
  // duplicates, stale ids and pure noise.
  task automatic send_random_item();
    int              r;
    logic            c;
    logic [ID_W-1:0] id;
    r = $urandom_range(99);
    c = 1'b0;
    if (r < 60) id = last_id_q + 8'($urandom_range(1, 4));
    else if (r < 70) id = last_id_q + 8'($urandom_range(1, 127));
    else if (r < 78) begin
      c  = 1'b1;
      id = 8'($urandom);
    end else if (r < 85) id = last_id_q;
    else if (r < 92) id = last_id_q - 8'($urandom_range(1, 128));
    else begin
      c  = 1'($urandom);
      id = 8'($urandom);
    end
    send_item(c, id, 1'b0, '0);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] d);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = d;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_WINDOW:  win_cfg = d;
      REG_INC_PCT: inc_cfg = d[PCT_W-1:0];
      REG_DEC_PCT: dec_cfg = d[PCT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic start_phase(logic [CNT_W-1:0] win, logic [PCT_W-1:0] inc,
                             logic [PCT_W-1:0] dec, idle_mode_e mode);
    logic [8:0] junk;
    wait_drained();
    write_reg(REG_WINDOW, win);
    // The upper data bits are outside the threshold registers and must be dropped.
    junk = 9'($urandom);
    write_reg(REG_INC_PCT, {junk, inc});
    junk = 9'($urandom);
    write_reg(REG_DEC_PCT, {junk, dec});
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 86; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 86; end
      default:   begin send_idle_pct = 14; recv_stall_pct = 14; end
    endcase
    phases++;
  endtask

  // Result side: random stalls, and a long hold-off when requested.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_token) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready = 1'b0;
      end else begin
        out_if.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("status of unexpected item", out_if.status, 0);
      end else begin
        want_r = expected_q.pop_front();
        if (out_if.status !== want_r.status)
          report_mismatch("status", out_if.status, want_r.status);
        if (out_if.gap !== want_r.gap)
          report_mismatch("gap", out_if.gap, want_r.gap);
        if (out_if.quality_level !== want_r.level)
          report_mismatch("quality_level", out_if.quality_level, want_r.level);
      end
      results_seen++;
      case (out_if.status)
        STATUS_ACCEPTED: n_accepted++;
        STATUS_REJECTED: n_rejected++;
        STATUS_CORRUPT:  n_corrupt++;
        default: ;
      endcase
      if (out_if.quality_level <= LEVEL_MAX) levels_seen[out_if.quality_level] = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.cmd       = 1'b0;
    in_if.packet_id = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part under reset configuration: duplicates, stale ids, the
    // 128-ahead case, wrap of the top id bit, the largest gap and corrupts.
    add_row(1'b0, 8'h00, 1'b1, STATUS_REJECTED, 7'd0,   LEVEL_MAX);
    add_row(1'b0, 8'h01, 1'b1, STATUS_ACCEPTED, 7'd0,   LEVEL_MAX);
    add_row(1'b0, 8'h05, 1'b1, STATUS_ACCEPTED, 7'd3,   LEVEL_MAX);
    add_row(1'b0, 8'h03, 1'b1, STATUS_REJECTED, 7'd0,   LEVEL_MAX);
    add_row(1'b0, 8'h85, 1'b1, STATUS_REJECTED, 7'd0,   LEVEL_MAX);
    add_row(1'b0, 8'h84, 1'b1, STATUS_ACCEPTED, 7'd126, LEVEL_MAX);
    add_row(1'b1, 8'hFF, 1'b1, STATUS_CORRUPT,  7'd0,   LEVEL_MAX);
    add_row(1'b0, 8'hFF, 1'b1, STATUS_ACCEPTED, 7'd122, LEVEL_MAX);
    add_row(1'b0, 8'h7F, 1'b1, STATUS_REJECTED, 7'd0,   LEVEL_MAX);
    add_row(1'b0, 8'h00, 1'b1, STATUS_ACCEPTED, 7'd0,   LEVEL_MAX);
    add_row(1'b0, 8'h80, 1'b1, STATUS_REJECTED, 7'd0,   LEVEL_MAX);
    add_row(1'b0, 8'h7F, 1'b1, STATUS_ACCEPTED, 7'd126, LEVEL_MAX);
    add_row(1'b1, 8'h00, 1'b1, STATUS_CORRUPT,  7'd0,   LEVEL_MAX);
    add_row(1'b0, 8'h80, 1'b0, STATUS_ACCEPTED, 7'd0,   LEVEL_MAX);
    add_row(1'b0, 8'hC0, 1'b0, STATUS_ACCEPTED, 7'd0,   LEVEL_MAX);
    add_row(1'b1, 8'h55, 1'b0, STATUS_CORRUPT,  7'd0,   LEVEL_MAX);
    add_row(1'b0, 8'h40, 1'b0, STATUS_REJECTED, 7'd0,   LEVEL_MAX);
    add_row(1'b0, 8'h3F, 1'b0, STATUS_ACCEPTED, 7'd0,   LEVEL_MAX);
    add_row(1'b0, 8'hAA, 1'b0, STATUS_ACCEPTED, 7'd0,   LEVEL_MAX);
    foreach (dir_table[i])
      send_item(dir_table[i].cmd, dir_table[i].id, dir_table[i].typed, dir_table[i].want);

    wait_drained();
    // Index 3 names no register; the write must leave the block unchanged.
    write_reg(REG_UNUSED, 16'($urandom));

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: start_phase(16'd5, 7'd5, 7'd10, IDLE_NONE);
        1: start_phase(16'd1, 7'd0, 7'd0, IDLE_SEND);
        2: start_phase(16'd0, 7'd100, 7'd100, IDLE_RECV);
        3: start_phase(16'd3, 7'd127, 7'd127, IDLE_BOTH);
        4: start_phase(16'd2, 7'd50, 7'd60, IDLE_NONE);
        5: start_phase(16'd10, 7'($urandom_range(127)), 7'($urandom_range(127)), IDLE_SEND);
        6: start_phase(16'($urandom_range(1, 8)), 7'($urandom_range(127)),
                       7'($urandom_range(127)), IDLE_RECV);
        default: start_phase(WINDOW_RESET, INC_PCT_RESET, DEC_PCT_RESET, IDLE_BOTH);
      endcase
      // Hold the result side off while items keep coming, so the block backs up.
      if (ph == 4) hold_token++;
      repeat (PHASE_ITEMS) send_random_item();
    end

    // Counter saturation. A corrupt then a good packet with window zero leave
    // the counters at one received and none missing.
    start_phase(16'd0, 7'd5, 7'd10, IDLE_NONE);
    send_item(1'b1, 8'h00, 1'b0, '0);
    send_good(last_id_q + 8'd1);
    start_phase(CNT_MAX, 7'd5, 7'd10, IDLE_NONE);
    // Largest gaps on every packet drive the missing count into saturation.
    repeat (540) send_good(last_id_q + 8'd127);
    repeat (5) send_item(1'b1, 8'($urandom), 1'b0, '0);
    repeat (20) send_random_item();

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d packet events over %0d configuration phases.", items_sent, phases);
    $display("Results: %0d accepted, %0d rejected, %0d corrupt; levels seen %b; %s",
             n_accepted, n_rejected, n_corrupt, levels_seen[5:1],
             "missing count driven into saturation.");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/plqa_pkg.sv
sv/plqa_if.sv
sv/plqa_id_check.sv
sv/plqa_level_ctrl.sv
sv/packet_loss_quality_adapter_top.sv
sim/tb_packet_loss_quality_adapter_top.sv
